>>> rtl/shamd_pkg.sv
// Shared types, constants and round functions for the SHA-256 message digest.
// Used by shamd_sched and sha256_message_digest; depends on nothing else.
`timescale 1ns / 1ps

package shamd_pkg;

    // Top-level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    // Padding progress within the final block(s) of a message
    typedef enum logic [2:0] {
        PH_NONE,
        PH_MARK,
        PH_ZERO_WRAP,
        PH_ZERO,
        PH_LEN,
        PH_DONE
    } phase_t;

    // Control from the sequencer to the message schedule window
    typedef struct packed {
        logic       wr_en;
        logic [5:0] pos;
        logic [7:0] data;
        logic       shift;
    } sched_ctrl_t;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return rotr32(x, 17) ^ rotr32(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr32(x, 2) ^ rotr32(x, 13) ^ rotr32(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr32(x, 6) ^ rotr32(x, 11) ^ rotr32(x, 25);
    endfunction

endpackage

>>> rtl/shamd_sched.sv
// Message block buffer and schedule window: 16 words, byte writes, one shift per round.
// Depends on shamd_pkg for the control struct and the small sigma functions.
`timescale 1ns / 1ps

module shamd_sched (
    input  logic                   clk,
    input  shamd_pkg::sched_ctrl_t ctrl,
    output logic [31:0]            w_cur
);
    import shamd_pkg::*;

    logic [31:0] window_reg [16];
    logic [31:0] expand;
    logic [1:0]  lane_sel;

    // Window holds W[t..t+15]; next word for the tail
    always_comb
    begin
        expand   = small_sig1(window_reg[14]) + window_reg[9]
                 + small_sig0(window_reg[1]) + window_reg[0];
        lane_sel = 2'd3 - ctrl.pos[1:0];
    end

    assign w_cur = window_reg[0];

    // Shift during rounds, otherwise take message or pad bytes big-endian
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            for (int i = 0; i < 15; i++)
            begin
                window_reg[i] <= window_reg[i + 1];
            end
            window_reg[15] <= expand;
        end
        else if (ctrl.wr_en)
        begin
            window_reg[ctrl.pos[5:2]][{lane_sel, 3'b000} +: 8] <= ctrl.data;
        end
    end

endmodule

>>> rtl/sha256_message_digest.sv
// SHA-256 over a byte stream: sequencer, round unit, chaining value and digest output.
// Depends on shamd_pkg and instantiates shamd_sched.
`timescale 1ns / 1ps

// Message bytes enter one per transaction on the msg channel; a transaction
// with byte_present low and last_byte high ends the message without a byte
// (an empty message right after reset or after a digest). A byte that does
// not complete a 64-byte block leaves msg_stall low unless it ends the
// message. A byte that completes a block is followed by 64 rounds through
// the single shared round unit and a fold of the result into the chaining
// value; msg_stall stays high through the rounds and the fold. On last_byte
// the block writes the pad bytes one per cycle into the block buffer (up to
// 64 bytes per padded block), runs one or two more compressions, then
// presents the eight digest words on the digest channel, word 0 first, one
// per transaction, and returns to the initial hash value. The byte count
// wraps modulo 2^61.
module sha256_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  logic [7:0]  message_byte,
    input  logic        byte_present,
    input  logic        last_byte,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import shamd_pkg::*;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    phase_t      ph_after;
    logic [5:0]  pos_reg, pos_next;
    logic [60:0] count_reg, count_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  round_reg;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] chain_reg [8];
    logic [31:0] work_reg [8];

    logic        msg_accept;
    logic        digest_accept;
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic        start_round;
    logic [2:0]  len_sel;
    logic [7:0]  len_byte;
    sched_ctrl_t sched_ctrl;
    logic [31:0] w_cur;

    logic [31:0] sig1_e, choose, sig0_a, major, tmp1, tmp2;

    assign msg_accept    = msg_valid & ~msg_stall;
    assign digest_accept = digest_valid & ~digest_stall;

    // Length byte for the tail of the final block, most significant first
    assign len_sel  = 3'd7 - pos_reg[2:0];
    assign len_byte = len_reg[{len_sel, 3'b000} +: 8];

    // Next state and sequencing
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        ph_after    = phase_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        wr_en       = 1'b0;
        wr_byte     = '0;
        start_round = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_accept)
                begin
                    if (byte_present)
                    begin
                        wr_en      = 1'b1;
                        wr_byte    = message_byte;
                        pos_next   = pos_reg + 6'd1;
                        count_next = count_reg + 61'd1;
                        if (pos_reg == 6'd63)
                        begin
                            state_next  = ST_ROUND;
                            start_round = 1'b1;
                            if (last_byte)
                            begin
                                phase_next = PH_MARK;
                            end
                        end
                        else if (last_byte)
                        begin
                            state_next = ST_PAD;
                            phase_next = PH_MARK;
                        end
                    end
                    else if (last_byte)
                    begin
                        state_next = ST_PAD;
                        phase_next = PH_MARK;
                    end
                end
            end
            ST_PAD:
            begin
                wr_en    = 1'b1;
                pos_next = pos_reg + 6'd1;
                case (phase_reg)
                    PH_MARK: wr_byte = PAD_MARK;
                    PH_LEN:  wr_byte = len_byte;
                    default: wr_byte = '0;
                endcase
                // Latch the bit length and clear the count for the next message
                if (phase_reg == PH_MARK)
                begin
                    len_next   = {count_reg, 3'b000};
                    count_next = '0;
                    ph_after   = (pos_reg[5:3] == 3'b111) ? PH_ZERO_WRAP : PH_ZERO;
                end
                phase_next = ph_after;
                if (pos_reg == 6'd63)
                begin
                    state_next  = ST_ROUND;
                    start_round = 1'b1;
                    phase_next  = (ph_after == PH_LEN) ? PH_DONE : PH_ZERO;
                end
                else if (pos_reg == 6'd55 && ph_after == PH_ZERO)
                begin
                    phase_next = PH_LEN;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (phase_reg == PH_DONE)
                begin
                    state_next = ST_EMIT;
                end
                else if (phase_reg == PH_NONE)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                if (digest_accept)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                        phase_next = PH_NONE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and digest outputs
    always_comb
    begin
        msg_stall    = (state_reg != ST_IDLE);
        digest_valid = (state_reg == ST_EMIT);
        digest_word  = chain_reg[idx_reg];
        word_index   = idx_reg;
        last_word    = (idx_reg == 3'd7);
    end

    // Schedule window control
    always_comb
    begin
        sched_ctrl.wr_en = wr_en;
        sched_ctrl.pos   = pos_reg;
        sched_ctrl.data  = wr_byte;
        sched_ctrl.shift = (state_reg == ST_ROUND);
    end

    shamd_sched u_sched (
        .clk   (clk),
        .ctrl  (sched_ctrl),
        .w_cur (w_cur)
    );

    // One compression round on the working variables
    always_comb
    begin
        sig1_e = big_sig1(work_reg[4]);
        choose = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        sig0_a = big_sig0(work_reg[0]);
        major  = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
        tmp1   = work_reg[7] + sig1_e + choose + ROUND_K[round_reg] + w_cur;
        tmp2   = sig0_a + major;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_NONE;
            pos_reg   <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (start_round)
            begin
                round_reg <= '0;
            end
            else if (state_reg == ST_ROUND)
            begin
                round_reg <= round_reg + 6'd1;
            end
        end
    end

    // Chaining value: fold in after each block, restore after the digest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
        else if (state_reg == ST_UPDATE)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
        end
        else if (digest_accept && idx_reg == 3'd7)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
    end

    // Working variables and latched bit length
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        if (start_round)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (state_reg == ST_ROUND)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + tmp1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= tmp1 + tmp2;
        end
    end

    // Digest words leave in order
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest_accept && !last_word) |=> (word_index == $past(word_index) + 3'd1))
        else $error("digest word order broken");

    // Exactly 64 rounds per block before the fold
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == 6'd63) |=> (state_reg == ST_UPDATE))
        else $error("round count overrun");

    // Padding always ends on a block boundary
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest_valid) |-> (pos_reg == 6'd0))
        else $error("digest started off a block boundary");

    // No padding left pending when taking bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (phase_reg == PH_NONE))
        else $error("idle with padding pending");

endmodule

>>> sim/sha256_message_digest_tb.sv
// Self-checking testbench for sha256_message_digest: byte-stream stimulus, digest checking.
// Depends on the RTL top level only; carries its own SHA-256 predictor.
`timescale 1ns / 1ps

module sha256_message_digest_tb;

    // One message-channel transaction
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       fin;
    } byte_xact_t;

    // One digest-channel transaction
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } word_xact_t;

    localparam logic [7:0] PAD_BYTE       = 8'h80;
    localparam int         IDLE_PERCENT   = 26;
    localparam int         RANDOM_ITEMS   = 470;
    localparam int         HOLDOFF_LEN    = 400;
    localparam int         HOLDOFF_AFTER  = 20;
    localparam int         DRAIN_CYCLES   = 400;
    localparam int         QUIET_START    = 1500;
    localparam int         QUIET_STOP     = 3500;
    localparam int         TIMEOUT_CYCLES = 1000000;

    // Ways a message can end
    localparam int         END_ON_BYTE    = 0;
    localparam int         END_SPLIT      = 1;
    localparam int         END_RANDOM     = 2;

    localparam logic [31:0] IV_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        msg_valid    = 1'b0;
    logic        msg_stall;
    logic [7:0]  message_byte = 8'h00;
    logic        byte_present = 1'b0;
    logic        last_byte    = 1'b0;
    logic        digest_valid;
    logic        digest_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    // Predictor state
    logic [31:0] hash_state [8];
    logic [7:0]  block_bytes [64];
    logic [60:0] byte_count;

    byte_xact_t  pending_bytes [$];
    word_xact_t  expected_words [$];

    int          error_count   = 0;
    int          cycle_count   = 0;
    int          words_taken   = 0;
    int          stim_count    = 0;
    int          holdoff_left  = 0;
    logic        holdoff_done  = 1'b0;
    logic        msg_fired     = 1'b0;
    logic        quiet_window;

    assign quiet_window = (cycle_count >= QUIET_START) && (cycle_count < QUIET_STOP);

    sha256_message_digest dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .message_byte (message_byte),
        .byte_present (byte_present),
        .last_byte    (last_byte),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // SHA-256 predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // Run the 64-round compression over block_bytes into hash_state
    task automatic hash_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1;
        int          i;
        for (i = 0; i < 16; i++)
        begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
        end
        for (i = 16; i < 64; i++)
        begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (i = 0; i < 64; i++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + K_TAB[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    // Return to the initial hash value and an empty message
    task automatic restart_chain();
        int j;
        for (j = 0; j < 8; j++)
            hash_state[j] = IV_TAB[j];
        byte_count = '0;
    endtask

    // Absorb one accepted transaction; on last, pad and queue the eight digest words
    task automatic predict_digest(input logic [7:0] data, input logic present,
                                  input logic fin);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        word_xact_t  w;
        int          j;
        if (present)
        begin
            pos = byte_count[5:0];
            block_bytes[pos] = data;
            byte_count = byte_count + 61'd1;
            if (pos == 6'd63)
                hash_block();
        end
        if (fin)
        begin
            pos = byte_count[5:0];
            block_bytes[pos] = PAD_BYTE;
            for (j = pos + 1; j < 64; j++)
                block_bytes[j] = 8'h00;
            if (pos >= 6'd56)
            begin
                hash_block();
                for (j = 0; j < 64; j++)
                    block_bytes[j] = 8'h00;
            end
            bit_len = {byte_count, 3'b000};
            for (j = 0; j < 8; j++)
                block_bytes[63-j] = bit_len[8*j +: 8];
            hash_block();
            for (j = 0; j < 8; j++)
            begin
                w.word = hash_state[j];
                w.idx  = j[2:0];
                w.last = (j == 7);
                expected_words.push_back(w);
            end
            restart_chain();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic add_item(input logic [7:0] data, input logic present, input logic fin);
        byte_xact_t x;
        x.data    = data;
        x.present = present;
        x.fin     = fin;
        pending_bytes.push_back(x);
        stim_count++;
    endtask

    // Mostly uniform bytes, with the extremes and the pad value mixed in
    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 8'h00;
        else if (sel == 1)
            return 8'hff;
        else if (sel == 2)
            return PAD_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Queue one message of len bytes, ending on the last byte or on an empty transaction
    task automatic add_message(input int len, input int end_mode);
        logic split;
        int   k;
        if (len == 0)
            split = 1'b1;
        else if (end_mode == END_ON_BYTE)
            split = 1'b0;
        else if (end_mode == END_SPLIT)
            split = 1'b1;
        else
            split = ($urandom_range(0, 2) == 0);
        for (k = 0; k < len; k++)
        begin
            // Mix in an occasional empty transaction that changes nothing
            if ($urandom_range(0, 24) == 0)
                add_item(pick_byte(), 1'b0, 1'b0);
            add_item(pick_byte(), 1'b1, !split && (k == len - 1));
        end
        if (split)
            add_item(pick_byte(), 1'b0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next transaction, hold it until accepted
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        byte_xact_t x;
        if (rst_n && (!msg_valid || msg_fired))
        begin
            if (pending_bytes.size() != 0
                && (quiet_window || $urandom_range(0, 99) >= IDLE_PERCENT))
            begin
                x = pending_bytes.pop_front();
                msg_valid    <= 1'b1;
                message_byte <= x.data;
                byte_present <= x.present;
                last_byte    <= x.fin;
            end
            else
            begin
                msg_valid <= 1'b0;
            end
        end
    end

    // Count down the one long receiver hold-off
    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
            if (holdoff_left == 1)
                holdoff_done <= 1'b1;
        end
        else if (!holdoff_done && words_taken >= HOLDOFF_AFTER)
        begin
            holdoff_left <= HOLDOFF_LEN;
        end
    end

    // Receiver: stall at random, and hard during the hold-off
    always @(negedge clk)
    begin
        digest_stall <= (holdoff_left > 0)
                     || (!quiet_window && ($urandom_range(0, 99) < IDLE_PERCENT));
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each input transaction, check each digest word
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        word_xact_t exp_w;
        cycle_count <= cycle_count + 1;
        msg_fired   <= rst_n && msg_valid && !msg_stall;
        if (rst_n && msg_valid && !msg_stall)
            predict_digest(message_byte, byte_present, last_byte);
        if (rst_n && digest_valid && !digest_stall)
        begin
            words_taken <= words_taken + 1;
            if (expected_words.size() == 0)
            begin
                if (error_count < 10)
                    $display("unexpected digest word %h idx %0d last %0b",
                             digest_word, word_index, last_word);
                error_count++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (digest_word !== exp_w.word || word_index !== exp_w.idx
                    || last_word !== exp_w.last)
                begin
                    if (error_count < 10)
                        $display("mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                                 exp_w.word, exp_w.idx, exp_w.last,
                                 digest_word, word_index, last_word);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        restart_chain();
        add_message(0, END_SPLIT);
        add_message(1, END_ON_BYTE);
        add_message(55, END_ON_BYTE);
        add_message(56, END_SPLIT);
        add_message(63, END_ON_BYTE);
        add_message(64, END_ON_BYTE);
        add_message(119, END_SPLIT);
        add_message(2, END_ON_BYTE);
        while (stim_count < RANDOM_ITEMS)
            add_message($urandom_range(0, 16), END_RANDOM);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_bytes.size() != 0 || msg_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("sha256_message_digest_tb: clean");
        else
            $display("sha256_message_digest_tb: errors");
        $finish;
    end

    // Stop a run that hangs
    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("sha256_message_digest_tb: errors");
        $finish;
    end

endmodule

>>> files.f
rtl/shamd_pkg.sv
rtl/shamd_sched.sv
rtl/sha256_message_digest.sv
sim/sha256_message_digest_tb.sv
